/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, ignored while rst is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Check cons in the cycle after ante, ignored while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

// Check cons in the cycle after ante, also across reset.
`define ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check across reset");

`endif

/* rtl/tcw_pkg.sv */
package tcw_pkg;

   // Screen geometry
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   // Field widths
   localparam int KIND_W = 3;
   localparam int CH_W   = 8;
   localparam int ATTR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int OFS_W  = 11;
   localparam int CELL_W = 16;
   localparam int REQ_W  = 32;
   localparam int RSP_W  = 40;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_PRINT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MARK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

   // Character codes and blank attribute after reset
   localparam logic [CH_W-1:0]   CH_NEWLINE   = 8'd10;
   localparam logic [CH_W-1:0]   CH_BACKSPACE = 8'd8;
   localparam logic [CH_W-1:0]   CH_BLANK     = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd7;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch;   // capture the incoming item
      logic exec;    // apply cursor update and single cell write
      logic copy;    // one step of the scroll copy
      logic drain;   // flush last copy write, aim counter at bottom row
      logic fill;    // blank one cell with the programmed attribute
      logic init;    // blank one cell with the reset attribute
      logic load;    // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_clear;
      logic need_scroll;
      logic copy_last;
      logic fill_last;
   } sts_type;

   // Linear cell address of a position
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_addr = ADDR_W'(int'(r) * COLS + int'(c));
   endfunction

endpackage

/* rtl/tcw_dp.sv */
module tcw_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  tcw_pkg::cmd_type                cmd,
   output tcw_pkg::sts_type                sts,
   input  logic [tcw_pkg::REQ_W-1:0]       req_tdata,
   input  logic [tcw_pkg::KIND_W-1:0]      req_tuser,
   input  logic                            csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]      csr_data,
   output logic [tcw_pkg::RSP_W-1:0]       rsp_tdata
);

   // Latched item
   logic [tcw_pkg::KIND_W-1:0] kind_ff;
   logic [tcw_pkg::CH_W-1:0]   ch_ff;
   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic [tcw_pkg::COL_W-1:0]  col_ff;
   logic [tcw_pkg::ROW_W-1:0]  row_ff;

   // Cursor, mark, attribute, sweep counter
   logic [tcw_pkg::COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]  mark_col_ff, mark_col_in;
   logic [tcw_pkg::ROW_W-1:0]  mark_row_ff, mark_row_in;
   logic [tcw_pkg::ATTR_W-1:0] normal_attr_ff;
   logic [tcw_pkg::ADDR_W-1:0] cnt_ff;
   logic                       scroll_ff, scroll_in;

   // Screen store and its ports
   logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;
   logic [tcw_pkg::ADDR_W-1:0] raddr;
   logic                       we;
   logic [tcw_pkg::ADDR_W-1:0] waddr;
   logic [tcw_pkg::CELL_W-1:0] wdata;
   logic                       cp_vld_ff;
   logic [tcw_pkg::ADDR_W-1:0] cp_addr_ff;

   logic [tcw_pkg::RSP_W-1:0]  rsp_ff;

   logic [tcw_pkg::ADDR_W-1:0] here;
   logic [tcw_pkg::ADDR_W-1:0] mark;
   logic [tcw_pkg::ADDR_W-1:0] rd_addr;
   logic                       rd_ok;
   logic                       col_last;
   logic                       row_last;
   logic                       ex_we;
   logic [tcw_pkg::ADDR_W-1:0] ex_waddr;
   logic [tcw_pkg::CELL_W-1:0] ex_wdata;
   logic [tcw_pkg::CELL_W-1:0] cell_out;

   assign here     = tcw_pkg::cell_addr(cur_row_ff, cur_col_ff);
   assign mark     = tcw_pkg::cell_addr(mark_row_ff, mark_col_ff);
   assign rd_addr  = tcw_pkg::cell_addr(row_ff, col_ff);
   assign rd_ok    = (int'(col_ff) < tcw_pkg::COLS) && (int'(row_ff) < tcw_pkg::ROWS);
   assign col_last = cur_col_ff == tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
   assign row_last = cur_row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

   // Work out the operation's cursor move and cell write
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      mark_col_in = mark_col_ff;
      mark_row_in = mark_row_ff;
      scroll_in   = 1'b0;
      ex_we       = 1'b0;
      ex_waddr    = here;
      ex_wdata    = {attr_ff, ch_ff};
      unique case (kind_ff)
         tcw_pkg::KIND_PRINT: begin
            priority if (ch_ff == tcw_pkg::CH_NEWLINE) begin
               cur_col_in = '0;
               if (row_last) scroll_in = 1'b1;
               else          cur_row_in = cur_row_ff + 1'b1;
            end else if (ch_ff == tcw_pkg::CH_BACKSPACE) begin
               // step back only past the prompt mark; same linear cell either way
               if (here > mark) begin
                  ex_we    = 1'b1;
                  ex_waddr = here - tcw_pkg::ADDR_W'(1);
                  ex_wdata = {normal_attr_ff, tcw_pkg::CH_BLANK};
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end else begin
                     cur_col_in = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
                     cur_row_in = cur_row_ff - 1'b1;
                  end
               end
            end else begin
               ex_we = 1'b1;
               if (col_last) begin
                  cur_col_in = '0;
                  if (row_last) scroll_in = 1'b1;
                  else          cur_row_in = cur_row_ff + 1'b1;
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
         end
         tcw_pkg::KIND_SET: begin
            cur_col_in = (int'(col_ff) < tcw_pkg::COLS) ? col_ff
                                                        : tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
            cur_row_in = (int'(row_ff) < tcw_pkg::ROWS) ? row_ff
                                                        : tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
         end
         tcw_pkg::KIND_CLEAR: begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
         tcw_pkg::KIND_MARK: begin
            mark_col_in = cur_col_ff;
            mark_row_in = cur_row_ff;
         end
         default: begin
         end
      endcase
   end

   assign sts.is_clear    = kind_ff == tcw_pkg::KIND_CLEAR;
   assign sts.need_scroll = scroll_in;
   assign sts.copy_last   = cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS - 1);
   assign sts.fill_last   = cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_tuser;
         ch_ff   <= req_tdata[7:0];
         attr_ff <= req_tdata[15:8];
         col_ff  <= req_tdata[22:16];
         row_ff  <= req_tdata[27:23];
      end
   end

   // Cursor, mark, attribute register and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         mark_col_ff    <= '0;
         mark_row_ff    <= '0;
         normal_attr_ff <= tcw_pkg::RESET_ATTR;
         cnt_ff         <= '0;
         scroll_ff      <= 1'b0;
         cp_vld_ff      <= 1'b0;
      end else begin
         if (csr_valid) normal_attr_ff <= csr_data;
         if (cmd.exec) begin
            cur_col_ff  <= cur_col_in;
            cur_row_ff  <= cur_row_in;
            mark_col_ff <= mark_col_in;
            mark_row_ff <= mark_row_in;
            scroll_ff   <= scroll_in;
         end
         priority if (cmd.exec)                        cnt_ff <= '0;
         else if (cmd.drain)
            cnt_ff <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
         else if (cmd.copy || cmd.fill || cmd.init)    cnt_ff <= cnt_ff + 1'b1;
         else                                          cnt_ff <= cnt_ff;
         cp_vld_ff <= cmd.copy;
      end
   end

   // Pick the write for this cycle
   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff;
      wdata = {normal_attr_ff, tcw_pkg::CH_BLANK};
      priority if (cp_vld_ff) begin
         we    = 1'b1;
         waddr = cp_addr_ff;
         wdata = rdata_ff;
      end else if (cmd.init) begin
         we    = 1'b1;
         wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_BLANK};
      end else if (cmd.fill) begin
         we    = 1'b1;
      end else if (cmd.exec) begin
         we    = ex_we;
         waddr = ex_waddr;
         wdata = ex_wdata;
      end else begin
         we    = 1'b0;
      end
   end

   // Copy reads one row ahead; otherwise read the requested cell
   assign raddr = cmd.copy ? cnt_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLS) : rd_addr;

   // Screen store
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff   <= mem[raddr];
      cp_addr_ff <= cnt_ff;
   end

   // Result register
   assign cell_out = (kind_ff == tcw_pkg::KIND_READ && rd_ok) ? rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= {scroll_ff, cell_out, tcw_pkg::OFS_W'(here), cur_row_ff, cur_col_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

/* rtl/tcw_ctrl.sv */
module tcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  tcw_pkg::sts_type sts,
   output tcw_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_COPY,
      S_DRAIN,
      S_FILL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      load;

   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Decode commands and next state
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cmd.load  = load;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            if (sts.fill_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.latch = req_tvalid;
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (sts.is_clear)   state_in = S_FILL;
            else if (sts.need_scroll)    state_in = S_COPY;
            else                         state_in = S_DONE;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/text_console_writer.sv */
// Text console writer: 80x25 screen of 16-bit cells (attribute high, char low).
// req channel: one operation per item, kind in tuser (print, set cursor,
//   clear, mark prompt, read cell). Items are taken one at a time.
// rsp channel: exactly one result per item with cursor, offset, cell data
//   and a scroll flag, held in an output register.
// csr channel: writes the blank attribute; always ready, takes effect at once.
// Flow: print, set cursor, mark and read go from accept through the execute
//   state to the done state, where the result loads; the next item is taken
//   the cycle after the result loads, so items are worked one at a time.
// A print that scrolls adds a row copy and a blanking pass: the copy runs
//   through the single read and single write port of the screen store, one
//   cell per cycle, then the bottom row is blanked one cell per cycle.
// Clear blanks every cell of the store, one blank write per cycle.
// Reset: cursor and mark go home, attribute returns to 7, then a clearing pass
//   blanks the store; req_tready stays low until it ends.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next item is accepted and worked meanwhile, and waits to load its result.
module text_console_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // ch[7:0], attr[15:8], col[22:16], row[27:23], zero[31:28]
   input  logic [tcw_pkg::REQ_W-1:0]   req_tdata,
   // kind[2:0]
   input  logic [tcw_pkg::KIND_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
   // cell_data[38:23], scrolled[39]
   output logic [tcw_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_data
);

   tcw_pkg::cmd_type cmd;
   tcw_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* rtl/tcw_checker.sv */
`include "assert_macros.svh"

module tcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tcw_pkg::RSP_W-1:0]   rsp_tdata
);

   // Stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Clearing pass blocks input right after reset
   `ASSERT_NEXT_RAW(a_init_blocks, clock, reset, !req_tready)

   // One item at a time: no accept on the following cycle
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // Reported offset matches reported row and column
   `ASSERT_SAME(a_offset, clock, reset, rsp_tvalid, 32'(rsp_tdata[22:12]) == ((32'(rsp_tdata[11:7]) * tcw_pkg::COLS + 32'(rsp_tdata[6:0])) & ((32'd1 << tcw_pkg::OFS_W) - 32'd1)))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
